// ===== sv/priority_schedule_timing_macros.svh =====
// Assertion macros shared by the priority scheduler RTL.
`ifndef PRIORITY_SCHEDULE_TIMING_MACROS_SVH
`define PRIORITY_SCHEDULE_TIMING_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define PST_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define PST_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle.
`define PST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pst_pkg.sv =====
// Package for the priority scheduler: beat types, table entry type and constants.
`timescale 1ns / 1ps
`default_nettype none

package pst_pkg;

    // Default job table depth.
    localparam int MAX_JOBS_DEF = 16;

    // Fixed field widths.
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int ID_W    = 4;
    localparam int TIME_W  = 20;
    localparam int AVG_W   = 28;
    localparam int FRAC_W  = 8;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [AVG_W-1:0]  AVG_MAX  = '1;

    // One job beat on the input channel.
    typedef struct packed {
        logic [BURST_W-1:0] burst_time;
        logic [PRIO_W-1:0]  job_priority;
        logic               last_job;
    } job_beat_t;

    // One schedule beat on the result channel.
    typedef struct packed {
        logic [ID_W-1:0]    job_id;
        logic [PRIO_W-1:0]  out_priority;
        logic [BURST_W-1:0] out_burst;
        logic [TIME_W-1:0]  waiting_time;
        logic [TIME_W-1:0]  turnaround_time;
        logic [AVG_W-1:0]   avg_wait_q8;
        logic [AVG_W-1:0]   avg_turnaround_q8;
        logic               overflow;
        logic               last_result;
    } result_beat_t;

    // One job table entry.
    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
    } job_entry_t;

endpackage

`default_nettype wire

// ===== sv/priority_schedule_timing.sv =====
// Top level of the non-preemptive priority scheduler.
`timescale 1ns / 1ps
`default_nettype none

// Jobs of a batch are taken one per cycle into a job table memory of MAX_JOBS
// entries (one write port, one registered read port); jobs beyond MAX_JOBS are
// dropped and reported through the overflow bit. The beat with last_job set
// closes the batch. Scheduling then walks the table in run order, lowest
// priority value first and ties by arrival: each pick is a scan of the n stored
// jobs through the memory read port. A first pass of n picks sums the waiting
// and turnaround times, a shift-subtract divider then forms both averages at
// one quotient bit per cycle, and a second pass of n picks sends one result
// beat per job, each after its own scan and held until the result channel
// takes it. No job beat is taken while a batch is being scheduled.
`include "priority_schedule_timing_macros.svh"

module priority_schedule_timing #(
    parameter int MAX_JOBS = pst_pkg::MAX_JOBS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 job_valid,
    output logic                      job_stall,
    input  wire pst_pkg::job_beat_t   job,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output pst_pkg::result_beat_t     result
);

    import pst_pkg::*;

    localparam int IDW  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW   = $clog2(MAX_JOBS + 1);
    localparam int FW   = BURST_W + CW;
    localparam int TW   = FW + CW;
    localparam int DW   = TW + FRAC_W;
    localparam int DCW  = $clog2(DW);
    localparam int KW   = PRIO_W + IDW;

    typedef enum logic [4:0] {
        ST_LOAD = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_STEP = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    // Job table memory.
    job_entry_t mem [MAX_JOBS];
    job_entry_t rd_data_reg;

    state_t           state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             pass_reg, pass_next;
    logic [CW-1:0]    scan_addr_reg, scan_addr_next;
    logic             rd_pend_reg, rd_pend_next;
    logic [IDW-1:0]   rd_id_reg, rd_id_next;
    logic             have_cur_reg, have_cur_next;
    logic [KW-1:0]    cur_key_reg, cur_key_next;
    logic             have_best_reg, have_best_next;
    logic [KW-1:0]    best_key_reg, best_key_next;
    logic [BURST_W-1:0] best_burst_reg, best_burst_next;
    logic [CW-1:0]    sel_cnt_reg, sel_cnt_next;
    logic [FW-1:0]    finish_reg, finish_next;
    logic [TW-1:0]    wait_sum_reg, wait_sum_next;
    logic [TW-1:0]    tat_sum_reg, tat_sum_next;
    logic [DW-1:0]    div_dq_reg, div_dq_next;
    logic [CW-1:0]    div_rem_reg, div_rem_next;
    logic [DCW-1:0]   div_cnt_reg, div_cnt_next;
    logic             div_sel_reg, div_sel_next;
    logic [AVG_W-1:0] avg_w_reg, avg_w_next;
    logic [AVG_W-1:0] avg_t_reg, avg_t_next;
    result_beat_t     result_reg, result_next;

    logic             job_fire;
    logic             table_full;
    logic             rd_en;
    logic [IDW-1:0]   rd_addr;
    logic             wr_en;
    logic [IDW-1:0]   wr_addr;
    job_entry_t       wr_data;

    logic [KW-1:0]    cand_key;
    logic             cand_after;
    logic             cand_better;
    logic             sel_last;
    logic [FW-1:0]    fin_new;
    logic [TW-1:0]    wait_sum_new;
    logic [TW-1:0]    tat_sum_new;
    logic [FW+TIME_W-1:0] wait_ext;
    logic [FW+TIME_W-1:0] tat_ext;
    logic [TIME_W-1:0] wait_sat;
    logic [TIME_W-1:0] tat_sat;
    logic [CW:0]      rem_sh;
    logic             rem_ge;
    logic [CW:0]      rem_sub;
    logic [DW-1:0]    dq_new;
    logic [DW+AVG_W-1:0] quo_ext;
    logic [AVG_W-1:0] quo_sat;

    // Handshake and memory port controls.
    assign job_stall    = (state_reg != ST_LOAD);
    assign job_fire     = job_valid && !job_stall;
    assign table_full   = (count_reg == CW'(MAX_JOBS));
    assign wr_en        = job_fire && !table_full;
    assign wr_addr      = count_reg[IDW-1:0];
    assign wr_data      = '{prio: job.job_priority, burst: job.burst_time};
    assign rd_en        = (state_reg == ST_SCAN) && (scan_addr_reg != count_reg);
    assign rd_addr      = scan_addr_reg[IDW-1:0];
    assign result_valid = (state_reg == ST_EMIT);
    assign result       = result_reg;

    // Compare the returned entry against the last pick and the best so far.
    assign cand_key    = {rd_data_reg.prio, rd_id_reg};
    assign cand_after  = !have_cur_reg || (cand_key > cur_key_reg);
    assign cand_better = !have_best_reg || (cand_key < best_key_reg);

    // Advance the running completion time and the sums by one pick.
    assign sel_last     = ((sel_cnt_reg + CW'(1)) == count_reg);
    assign fin_new      = finish_reg + FW'(best_burst_reg);
    assign wait_sum_new = wait_sum_reg + TW'(finish_reg);
    assign tat_sum_new  = tat_sum_reg + TW'(fin_new);
    assign wait_ext     = (FW + TIME_W)'(finish_reg);
    assign tat_ext      = (FW + TIME_W)'(fin_new);
    assign wait_sat     = (wait_ext > (FW + TIME_W)'(TIME_MAX)) ? TIME_MAX
                                                                : TIME_W'(finish_reg);
    assign tat_sat      = (tat_ext > (FW + TIME_W)'(TIME_MAX)) ? TIME_MAX
                                                               : TIME_W'(fin_new);

    // One restoring divide step by the job count.
    assign rem_sh  = {div_rem_reg, div_dq_reg[DW-1]};
    assign rem_ge  = (rem_sh >= {1'b0, count_reg});
    assign rem_sub = rem_ge ? (rem_sh - {1'b0, count_reg}) : rem_sh;
    assign dq_new  = {div_dq_reg[DW-2:0], rem_ge};
    assign quo_ext = (DW + AVG_W)'(dq_new);
    assign quo_sat = (quo_ext > (DW + AVG_W)'(AVG_MAX)) ? AVG_MAX : AVG_W'(dq_new);

    // Next-state and datapath control.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        pass_next       = pass_reg;
        scan_addr_next  = scan_addr_reg;
        rd_pend_next    = 1'b0;
        rd_id_next      = rd_id_reg;
        have_cur_next   = have_cur_reg;
        cur_key_next    = cur_key_reg;
        have_best_next  = have_best_reg;
        best_key_next   = best_key_reg;
        best_burst_next = best_burst_reg;
        sel_cnt_next    = sel_cnt_reg;
        finish_next     = finish_reg;
        wait_sum_next   = wait_sum_reg;
        tat_sum_next    = tat_sum_reg;
        div_dq_next     = div_dq_reg;
        div_rem_next    = div_rem_reg;
        div_cnt_next    = div_cnt_reg;
        div_sel_next    = div_sel_reg;
        avg_w_next      = avg_w_reg;
        avg_t_next      = avg_t_reg;
        result_next     = result_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                // Store the job, or drop it when the table is full.
                if (job_fire)
                begin
                    if (table_full)
                        ovf_next = 1'b1;
                    else
                        count_next = count_reg + CW'(1);
                    if (job.last_job)
                    begin
                        state_next     = ST_SCAN;
                        pass_next      = 1'b0;
                        scan_addr_next = '0;
                        have_best_next = 1'b0;
                    end
                end
            end

            ST_SCAN:
            begin
                // Issue one read per cycle across the stored jobs.
                if (rd_en)
                begin
                    scan_addr_next = scan_addr_reg + CW'(1);
                    rd_pend_next   = 1'b1;
                    rd_id_next     = rd_addr;
                end
                // Keep the smallest key above the last pick.
                if (rd_pend_reg && cand_after && cand_better)
                begin
                    have_best_next  = 1'b1;
                    best_key_next   = cand_key;
                    best_burst_next = rd_data_reg.burst;
                end
                if (rd_pend_reg && !rd_en)
                    state_next = ST_STEP;
            end

            ST_STEP:
            begin
                // Commit the pick and advance the schedule clock.
                have_cur_next = 1'b1;
                cur_key_next  = best_key_reg;
                sel_cnt_next  = sel_cnt_reg + CW'(1);
                finish_next   = fin_new;
                if (!pass_reg)
                begin
                    wait_sum_next = wait_sum_new;
                    tat_sum_next  = tat_sum_new;
                    if (sel_last)
                    begin
                        state_next   = ST_DIV;
                        div_dq_next  = {wait_sum_new, FRAC_W'(0)};
                        div_rem_next = '0;
                        div_cnt_next = '0;
                        div_sel_next = 1'b0;
                    end
                    else
                    begin
                        state_next     = ST_SCAN;
                        scan_addr_next = '0;
                        have_best_next = 1'b0;
                    end
                end
                else
                begin
                    state_next                    = ST_EMIT;
                    result_next.job_id            = ID_W'(best_key_reg[IDW-1:0]);
                    result_next.out_priority      = best_key_reg[KW-1:IDW];
                    result_next.out_burst         = best_burst_reg;
                    result_next.waiting_time      = wait_sat;
                    result_next.turnaround_time   = tat_sat;
                    result_next.avg_wait_q8       = avg_w_reg;
                    result_next.avg_turnaround_q8 = avg_t_reg;
                    result_next.overflow          = ovf_reg;
                    result_next.last_result       = sel_last;
                end
            end

            ST_DIV:
            begin
                // Shift in one quotient bit per cycle.
                div_dq_next  = dq_new;
                div_rem_next = rem_sub[CW-1:0];
                div_cnt_next = div_cnt_reg + DCW'(1);
                if (div_cnt_reg == DCW'(DW - 1))
                begin
                    if (!div_sel_reg)
                    begin
                        avg_w_next   = quo_sat;
                        div_dq_next  = {tat_sum_reg, FRAC_W'(0)};
                        div_rem_next = '0;
                        div_cnt_next = '0;
                        div_sel_next = 1'b1;
                    end
                    else
                    begin
                        // Restart the walk for the result pass.
                        avg_t_next     = quo_sat;
                        state_next     = ST_SCAN;
                        pass_next      = 1'b1;
                        finish_next    = '0;
                        sel_cnt_next   = '0;
                        have_cur_next  = 1'b0;
                        scan_addr_next = '0;
                        have_best_next = 1'b0;
                    end
                end
            end

            ST_EMIT:
            begin
                // Hold the result beat until taken.
                if (!result_stall)
                begin
                    if (result_reg.last_result)
                    begin
                        state_next    = ST_LOAD;
                        count_next    = '0;
                        ovf_next      = 1'b0;
                        pass_next     = 1'b0;
                        finish_next   = '0;
                        wait_sum_next = '0;
                        tat_sum_next  = '0;
                        sel_cnt_next  = '0;
                        have_cur_next = 1'b0;
                    end
                    else
                    begin
                        state_next     = ST_SCAN;
                        scan_addr_next = '0;
                        have_best_next = 1'b0;
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            pass_reg      <= 1'b0;
            scan_addr_reg <= '0;
            rd_pend_reg   <= 1'b0;
            have_cur_reg  <= 1'b0;
            have_best_reg <= 1'b0;
            sel_cnt_reg   <= '0;
            finish_reg    <= '0;
            wait_sum_reg  <= '0;
            tat_sum_reg   <= '0;
            div_cnt_reg   <= '0;
            div_sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            pass_reg      <= pass_next;
            scan_addr_reg <= scan_addr_next;
            rd_pend_reg   <= rd_pend_next;
            have_cur_reg  <= have_cur_next;
            have_best_reg <= have_best_next;
            sel_cnt_reg   <= sel_cnt_next;
            finish_reg    <= finish_next;
            wait_sum_reg  <= wait_sum_next;
            tat_sum_reg   <= tat_sum_next;
            div_cnt_reg   <= div_cnt_next;
            div_sel_reg   <= div_sel_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rd_id_reg      <= rd_id_next;
        cur_key_reg    <= cur_key_next;
        best_key_reg   <= best_key_next;
        best_burst_reg <= best_burst_next;
        div_dq_reg     <= div_dq_next;
        div_rem_reg    <= div_rem_next;
        avg_w_reg      <= avg_w_next;
        avg_t_reg      <= avg_t_next;
        result_reg     <= result_next;
    end

    // Job table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    `PST_ASSERT_IMPLIES(a_no_rw_clash, rd_en, !wr_en, "table read and write in one cycle")
    `PST_ASSERT_HOLDS(a_count_cap, count_reg <= CW'(MAX_JOBS), "job count above table depth")
    `PST_ASSERT_IMPLIES(a_sel_bound, state_reg == ST_SCAN || state_reg == ST_STEP,
        sel_cnt_reg < count_reg, "pick count past batch size")
    `PST_ASSERT_IMPLIES(a_div_rem, state_reg == ST_DIV, div_rem_reg < count_reg,
        "divider remainder not below job count")
    `PST_ASSERT_NEXT(a_batch_clear, result_valid && !result_stall && result.last_result,
        state_reg == ST_LOAD && count_reg == '0 && !ovf_reg,
        "batch state not cleared after last beat")

endmodule

`default_nettype wire
